// ===== src/hlm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hlm_pkg;

  localparam int MAX_SOURCES    = 16;
  localparam int LEVEL_MAX      = 255;
  localparam int SOURCE_ID_BITS = 8;

  localparam int IDX_W = $clog2(MAX_SOURCES);
  localparam int CNT_W = IDX_W + 1;
  localparam int KEY_W = 16;
  localparam int LVL_W = 8;

  localparam logic [KEY_W-1:0] FRONT_KEY_RST = 16'h7FFF;
  localparam logic [KEY_W-1:0] BACK_KEY_RST  = 16'h8000;

  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 32;

  localparam logic [1:0] KIND_REGISTER   = 2'd0;
  localparam logic [1:0] KIND_SET_LEVEL  = 2'd1;
  localparam logic [1:0] KIND_UNREGISTER = 2'd2;

  localparam logic [1:0] TYPE_CROSSFADER = 2'd1;
  localparam logic [1:0] TYPE_EDITOR     = 2'd2;

  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_DUPLICATE = 2'd1;
  localparam logic [1:0] STATUS_FULL      = 2'd2;
  localparam logic [1:0] STATUS_UNKNOWN   = 2'd3;

  localparam logic [1:0] REG_MERGE_MODE    = 2'd0;
  localparam logic [1:0] REG_DEFAULT_LEVEL = 2'd1;
  localparam logic [1:0] REG_BYPASS_MASTER = 2'd2;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] source_id;
    logic [1:0] source_type;
    logic [7:0] level;
    logic [7:0] master_level;
  } item_t;

  typedef struct packed {
    logic [7:0] merged_level;
    logic [7:0] output_level;
    logic       active_valid;
    logic [7:0] active_source;
    logic       override_active;
    logic [1:0] status;
  } result_t;

  typedef struct packed {
    logic       merge_mode;
    logic [7:0] default_level;
    logic       bypass_master;
  } cfg_t;

  typedef struct packed {
    logic [SOURCE_ID_BITS-1:0] src;
    logic [LVL_W-1:0]          lvl;
    logic [KEY_W-1:0]          key;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic [LVL_W-1:0] level;
    logic [7:0]       master;
    logic             bypass;
  } scale_req_t;

  typedef struct packed {
    logic [7:0] merged_level;
    logic       active_valid;
    logic [7:0] active_source;
    logic       override_active;
    logic [1:0] status;
  } core_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY,
    ST_SCALE
  } st_e;

endpackage
`default_nettype wire

// ===== src/hlm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== src/hlm_cfg.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlm_cfg (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [hlm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [hlm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [hlm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready,
  output hlm_pkg::cfg_t                         cfg_o
);
  import hlm_pkg::*;

  logic       merge_mode_q, merge_mode_d;
  logic [7:0] default_level_q, default_level_d;
  logic       bypass_master_q, bypass_master_d;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[APB_ADDR_W-1:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_comb begin
    merge_mode_d    = merge_mode_q;
    default_level_d = default_level_q;
    bypass_master_d = bypass_master_q;
    if (wr_en) begin
      case (reg_idx)
        REG_MERGE_MODE:    merge_mode_d    = pwdata[0];
        REG_DEFAULT_LEVEL: default_level_d = pwdata[7:0];
        REG_BYPASS_MASTER: bypass_master_d = pwdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      merge_mode_q    <= 1'b0;
      default_level_q <= 8'd0;
      bypass_master_q <= 1'b0;
    end else begin
      merge_mode_q    <= merge_mode_d;
      default_level_q <= default_level_d;
      bypass_master_q <= bypass_master_d;
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MERGE_MODE:    prdata = APB_DATA_W'(merge_mode_q);
      REG_DEFAULT_LEVEL: prdata = APB_DATA_W'(default_level_q);
      REG_BYPASS_MASTER: prdata = APB_DATA_W'(bypass_master_q);
      default:           prdata = '0;
    endcase
  end

  assign cfg_o.merge_mode    = merge_mode_q;
  assign cfg_o.default_level = default_level_q;
  assign cfg_o.bypass_master = bypass_master_q;

endmodule
`default_nettype wire

// ===== src/hlm_scale.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlm_scale (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                go_i,
  input  wire hlm_pkg::scale_req_t req_i,
  output logic                     done_o,
  output logic [7:0]               level_o
);
  import hlm_pkg::*;

  localparam logic [16:0] Recip = 17'((32'd1 << 16) / LEVEL_MAX);

  logic        s1_vld_q, s2_vld_q, done_q;
  logic [15:0] prod1_q, prod2_q;
  logic [7:0]  lvl1_q, lvl2_q;
  logic        byp1_q, byp2_q;
  logic [15:0] quot_q;
  logic [7:0]  out_q;

  logic [32:0] recip_prod;
  logic [15:0] quot_est;
  logic [31:0] back_prod;
  logic [31:0] rem;
  logic [16:0] quot_fix;
  logic [7:0]  out_d;

  assign recip_prod = 33'(prod1_q) * 33'(Recip);
  assign quot_est   = recip_prod[31:16];

  assign back_prod = 32'(quot_q) * 32'(LEVEL_MAX);
  assign rem       = 32'(prod2_q) - back_prod;
  assign quot_fix  = 17'(quot_q) + 17'(rem >= 32'(LEVEL_MAX));

  always_comb begin
    if (byp2_q) begin
      out_d = lvl2_q;
    end else if (quot_fix > 17'd255) begin
      out_d = 8'hFF;
    end else begin
      out_d = quot_fix[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      s1_vld_q <= go_i;
      s2_vld_q <= s1_vld_q;
      done_q   <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod1_q <= 16'(req_i.level) * 16'(req_i.master);
    lvl1_q  <= 8'(req_i.level);
    byp1_q  <= req_i.bypass;
    quot_q  <= quot_est;
    prod2_q <= prod1_q;
    lvl2_q  <= lvl1_q;
    byp2_q  <= byp1_q;
    out_q   <= out_d;
  end

  assign done_o  = done_q;
  assign level_o = out_q;

endmodule
`default_nettype wire

// ===== src/hlm_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlm_core (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire hlm_pkg::item_t              item_i,
  input  wire hlm_pkg::cfg_t               cfg_i,
  output logic                             busy_o,
  output logic                             ram_re_o,
  output logic [hlm_pkg::IDX_W-1:0]        ram_raddr_o,
  input  wire hlm_pkg::entry_t             ram_rdata_i,
  output logic                             ram_we_o,
  output logic [hlm_pkg::IDX_W-1:0]        ram_waddr_o,
  output hlm_pkg::entry_t                  ram_wdata_o,
  output logic                             scale_go_o,
  output hlm_pkg::scale_req_t              scale_req_o,
  input  wire logic                        scale_done_i,
  output hlm_pkg::core_stat_t              stat_o
);
  import hlm_pkg::*;

  localparam int SID_W = SOURCE_ID_BITS;

  st_e state_q, state_d;

  item_t                item_q;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [MAX_SOURCES-1:0] valid_q, valid_d;
  logic [KEY_W-1:0]     front_key_q, front_key_d;
  logic [KEY_W-1:0]     back_key_q, back_key_d;
  logic                 ovr_vld_q, ovr_vld_d;
  logic [SID_W-1:0]     ovr_src_q, ovr_src_d;
  logic                 act_vld_q, act_vld_d;
  logic [SID_W-1:0]     act_src_q, act_src_d;
  logic [LVL_W-1:0]     cur_lvl_q, cur_lvl_d;
  logic [1:0]           status_q, status_d;
  logic                 found_q, found_d;
  logic                 best_vld_q, best_vld_d;
  logic                 free_any_q;
  logic [IDX_W-1:0]     free_idx_q;
  logic [IDX_W-1:0]     match_idx_q, match_idx_d;
  logic [KEY_W-1:0]     match_key_q, match_key_d;
  logic [LVL_W-1:0]     best_lvl_q, best_lvl_d;
  logic [KEY_W-1:0]     best_key_q, best_key_d;
  logic [SID_W-1:0]     best_src_q, best_src_d;

  logic                 free_any;
  logic [IDX_W-1:0]     free_idx;
  logic [SID_W-1:0]     item_id;
  logic [KEY_W-1:0]     new_key;
  logic [IDX_W-1:0]     scan_idx;
  logic                 accept;
  logic                 ram_we;
  logic [IDX_W-1:0]     ram_waddr;
  entry_t               ram_wdata;

  assign accept   = (state_q == ST_IDLE) && start_i;
  assign item_id  = SID_W'(item_q.source_id);
  assign new_key  = (item_q.source_type == TYPE_CROSSFADER) ? front_key_q : back_key_q;
  assign scan_idx = IDX_W'(cnt_q - CNT_W'(1));

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = MAX_SOURCES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  always_comb begin
    logic             ins;
    logic             hit;
    logic             c_vld;
    logic [LVL_W-1:0] c_lvl;
    logic [KEY_W-1:0] c_key;
    logic [SID_W-1:0] c_src;
    logic             ltp;
    logic             is_ovr;
    logic             ovr_after;

    ins       = 1'b0;
    hit       = 1'b0;
    c_vld     = 1'b0;
    c_lvl     = '0;
    c_key     = '0;
    c_src     = '0;
    ltp       = cfg_i.merge_mode;
    is_ovr    = ovr_vld_q && (ovr_src_q == item_id);
    ovr_after = ovr_vld_q;

    cnt_d       = cnt_q;
    valid_d     = valid_q;
    front_key_d = front_key_q;
    back_key_d  = back_key_q;
    ovr_vld_d   = ovr_vld_q;
    ovr_src_d   = ovr_src_q;
    act_vld_d   = act_vld_q;
    act_src_d   = act_src_q;
    cur_lvl_d   = cur_lvl_q;
    status_d    = status_q;
    found_d     = found_q;
    best_vld_d  = best_vld_q;
    match_idx_d = match_idx_q;
    match_key_d = match_key_q;
    best_lvl_d  = best_lvl_q;
    best_key_d  = best_key_q;
    best_src_d  = best_src_q;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;

    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cnt_d      = '0;
          found_d    = 1'b0;
          best_vld_d = 1'b0;
          status_d   = STATUS_OK;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q != '0) begin
          ins = (item_q.kind == KIND_REGISTER) && (item_q.source_type != TYPE_EDITOR) &&
                !ltp && free_any_q && (scan_idx == free_idx_q);
          hit = valid_q[scan_idx] && (ram_rdata_i.src == item_id);
          if (ins) begin
            c_vld = 1'b1;
            c_lvl = item_q.level;
            c_key = new_key;
            c_src = item_id;
          end else if (valid_q[scan_idx]) begin
            c_src = ram_rdata_i.src;
            c_key = ram_rdata_i.key;
            c_lvl = (item_q.kind == KIND_SET_LEVEL && hit) ? item_q.level : ram_rdata_i.lvl;
            c_vld = !(item_q.kind == KIND_UNREGISTER && hit);
          end
          if (hit) begin
            found_d     = 1'b1;
            match_idx_d = scan_idx;
            match_key_d = ram_rdata_i.key;
          end
          if (c_vld && (!best_vld_q || c_lvl > best_lvl_q ||
                        (c_lvl == best_lvl_q && c_key < best_key_q))) begin
            best_vld_d = 1'b1;
            best_lvl_d = c_lvl;
            best_key_d = c_key;
            best_src_d = c_src;
          end
        end
      end
      ST_APPLY: begin
        case (item_q.kind)
          KIND_REGISTER: begin
            if (found_q) begin
              status_d = STATUS_DUPLICATE;
            end else if (item_q.source_type == TYPE_EDITOR) begin
              ovr_vld_d = 1'b1;
              ovr_src_d = item_id;
              act_vld_d = 1'b1;
              act_src_d = item_id;
              cur_lvl_d = item_q.level;
            end else if (ltp) begin
              if (!ovr_vld_q) begin
                cur_lvl_d = item_q.level;
              end
            end else if (!free_any_q) begin
              status_d = STATUS_FULL;
            end else begin
              valid_d[free_idx_q] = 1'b1;
              ram_we    = 1'b1;
              ram_waddr = free_idx_q;
              ram_wdata = '{src: item_id, lvl: item_q.level, key: new_key};
              if (item_q.source_type == TYPE_CROSSFADER) begin
                front_key_d = front_key_q - KEY_W'(1);
              end else begin
                back_key_d = back_key_q + KEY_W'(1);
              end
              if (best_vld_q && !ovr_vld_q) begin
                act_vld_d = 1'b1;
                act_src_d = best_src_q;
                cur_lvl_d = best_lvl_q;
              end
            end
          end
          KIND_SET_LEVEL: begin
            if (is_ovr) begin
              cur_lvl_d = item_q.level;
            end else if (ltp && !ovr_vld_q) begin
              cur_lvl_d = item_q.level;
            end else begin
              if (found_q) begin
                ram_we    = 1'b1;
                ram_waddr = match_idx_q;
                ram_wdata = '{src: item_id, lvl: item_q.level, key: match_key_q};
              end else begin
                status_d = STATUS_UNKNOWN;
              end
              if (best_vld_q && !ovr_vld_q) begin
                act_vld_d = 1'b1;
                act_src_d = best_src_q;
                cur_lvl_d = best_lvl_q;
              end
            end
          end
          KIND_UNREGISTER: begin
            if (is_ovr) begin
              ovr_vld_d = 1'b0;
              act_vld_d = 1'b0;
              act_src_d = '0;
              ovr_after = 1'b0;
            end
            if (!ltp) begin
              if (found_q) begin
                valid_d[match_idx_q] = 1'b0;
              end else if (!is_ovr) begin
                status_d = STATUS_UNKNOWN;
              end
              if (!ovr_after) begin
                if (best_vld_q) begin
                  act_vld_d = 1'b1;
                  act_src_d = best_src_q;
                  cur_lvl_d = best_lvl_q;
                end else begin
                  act_vld_d = 1'b0;
                  act_src_d = '0;
                  cur_lvl_d = cfg_i.default_level;
                end
              end
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == CNT_W'(MAX_SOURCES)) begin
          state_d = ST_APPLY;
        end
      end
      ST_APPLY: state_d = ST_SCALE;
      ST_SCALE: begin
        if (scale_done_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    busy_o      = 1'b1;
    ram_re_o    = 1'b0;
    scale_go_o  = 1'b0;
    case (state_q)
      ST_IDLE:  busy_o     = 1'b0;
      ST_SCAN:  ram_re_o   = (cnt_q < CNT_W'(MAX_SOURCES));
      ST_APPLY: scale_go_o = 1'b1;
      default: ;
    endcase
  end

  assign ram_raddr_o = cnt_q[IDX_W-1:0];
  assign ram_we_o    = ram_we;
  assign ram_waddr_o = ram_waddr;
  assign ram_wdata_o = ram_wdata;

  assign scale_req_o.level  = cur_lvl_d;
  assign scale_req_o.master = item_q.master_level;
  assign scale_req_o.bypass = cfg_i.bypass_master;

  assign stat_o.merged_level    = cur_lvl_q;
  assign stat_o.active_valid    = act_vld_q;
  assign stat_o.active_source   = act_vld_q ? 8'(act_src_q) : 8'd0;
  assign stat_o.override_active = ovr_vld_q;
  assign stat_o.status          = status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      valid_q     <= '0;
      front_key_q <= FRONT_KEY_RST;
      back_key_q  <= BACK_KEY_RST;
      ovr_vld_q   <= 1'b0;
      ovr_src_q   <= '0;
      act_vld_q   <= 1'b0;
      act_src_q   <= '0;
      cur_lvl_q   <= '0;
      status_q    <= STATUS_OK;
      found_q     <= 1'b0;
      best_vld_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      valid_q     <= valid_d;
      front_key_q <= front_key_d;
      back_key_q  <= back_key_d;
      ovr_vld_q   <= ovr_vld_d;
      ovr_src_q   <= ovr_src_d;
      act_vld_q   <= act_vld_d;
      act_src_q   <= act_src_d;
      cur_lvl_q   <= cur_lvl_d;
      status_q    <= status_d;
      found_q     <= found_d;
      best_vld_q  <= best_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q     <= item_i;
      free_any_q <= free_any;
      free_idx_q <= free_idx;
    end
    match_idx_q <= match_idx_d;
    match_key_q <= match_key_d;
    best_lvl_q  <= best_lvl_d;
    best_key_q  <= best_key_d;
    best_src_q  <= best_src_d;
  end

endmodule
`default_nettype wire

// ===== src/htp_ltp_channel_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel merge for one lighting channel: each accepted command (start high while busy is low)
// registers, updates or unregisters a source and yields exactly one result, shown on result_o
// for the single cycle in which done_o is high; the receiver cannot stall, so capture it then.
// After acceptance, a command scans the source table through the single read port of its
// memory, one entry a cycle, then writes back in the apply state and passes a three-stage grand
// master scaler before the result is strobed; busy stays high until the scaler is done.
// Table valid bits are flip-flops cleared by reset, so no clearing pass is needed.
// Write configuration only while busy is low and no result is pending.
module htp_ltp_channel_merge (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire hlm_pkg::item_t                   item_i,
  output logic                                  done_o,
  output hlm_pkg::result_t                      result_o,
  input  wire logic                             psel,
  input  wire logic                             penable,
  input  wire logic                             pwrite,
  input  wire logic [hlm_pkg::APB_ADDR_W-1:0]   paddr,
  input  wire logic [hlm_pkg::APB_DATA_W-1:0]   pwdata,
  output logic      [hlm_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                  pready
);
  import hlm_pkg::*;

  cfg_t               cfg;
  logic               ram_re, ram_we;
  logic [IDX_W-1:0]   ram_raddr, ram_waddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  logic               scale_go, scale_done;
  scale_req_t         scale_req;
  logic [7:0]         scale_level;
  core_stat_t         stat;

  hlm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  hlm_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_SOURCES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  hlm_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start),
    .item_i       (item_i),
    .cfg_i        (cfg),
    .busy_o       (busy),
    .ram_re_o     (ram_re),
    .ram_raddr_o  (ram_raddr),
    .ram_rdata_i  (entry_t'(ram_rdata)),
    .ram_we_o     (ram_we),
    .ram_waddr_o  (ram_waddr),
    .ram_wdata_o  (ram_wdata),
    .scale_go_o   (scale_go),
    .scale_req_o  (scale_req),
    .scale_done_i (scale_done),
    .stat_o       (stat)
  );

  hlm_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .go_i    (scale_go),
    .req_i   (scale_req),
    .done_o  (scale_done),
    .level_o (scale_level)
  );

  assign done_o                   = scale_done;
  assign result_o.merged_level    = stat.merged_level;
  assign result_o.output_level    = scale_level;
  assign result_o.active_valid    = stat.active_valid;
  assign result_o.active_source   = stat.active_source;
  assign result_o.override_active = stat.override_active;
  assign result_o.status          = stat.status;

endmodule
`default_nettype wire

// ===== src/hlm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hlm_checker (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             done_o,
  input wire hlm_pkg::result_t result_o
);
  import hlm_pkg::*;

  localparam int Latency = MAX_SOURCES + 5;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##Latency done_o)
    else $error("result strobe missing after transfer");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("busy not raised after accepted transfer");

  a_idle_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> (!busy && !done_o))
    else $error("block not idle after result");

  a_source_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !result_o.active_valid) |-> (result_o.active_source == 8'd0))
    else $error("active source nonzero without active flag");

  a_override_active: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.override_active) |-> result_o.active_valid)
    else $error("override without active source");

endmodule

bind htp_ltp_channel_merge hlm_checker u_hlm_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .done_o   (done_o),
  .result_o (result_o)
);
`default_nettype wire

// ===== tb/htp_ltp_channel_merge_tb.sv =====
`timescale 1ns / 1ps
module htp_ltp_channel_merge_tb;
  import hlm_pkg::*;

  localparam logic [1:0] KIND_NONE     = 2'd3;
  localparam logic [1:0] TYPE_NORMAL   = 2'd0;
  localparam logic [1:0] TYPE_RESERVED = 2'd3;
  localparam int         POOL_SIZE     = 20;
  localparam int         SETTLE_CYCLES = 30;

  logic                  clk_i   = 1'b0;
  logic                  rst_ni  = 1'b0;
  logic                  start   = 1'b0;
  logic                  busy;
  item_t                 item_i  = '0;
  logic                  done_o;
  result_t               result_o;
  logic                  psel    = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite  = 1'b0;
  logic [APB_ADDR_W-1:0] paddr   = '0;
  logic [APB_DATA_W-1:0] pwdata  = '0;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  htp_ltp_channel_merge dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .item_i   (item_i),
    .done_o   (done_o),
    .result_o (result_o),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always #4 clk_i = ~clk_i;

  // channel state mirror
  logic             cfg_ltp     = 1'b0;
  logic [7:0]       cfg_default = 8'd0;
  logic             cfg_bypass  = 1'b0;
  bit               ent_valid[MAX_SOURCES];
  logic [7:0]       ent_src[MAX_SOURCES];
  logic [7:0]       ent_lvl[MAX_SOURCES];
  logic [KEY_W-1:0] ent_key[MAX_SOURCES];
  logic [KEY_W-1:0] front_key = FRONT_KEY_RST;
  logic [KEY_W-1:0] back_key  = BACK_KEY_RST;
  logic             ovr_valid = 1'b0;
  logic [7:0]       ovr_src   = 8'd0;
  logic             act_valid = 1'b0;
  logic [7:0]       act_src   = 8'd0;
  logic [7:0]       cur_lvl   = 8'd0;

  result_t    pending_results[$];
  logic [7:0] id_pool[POOL_SIZE];
  int         mismatch_count  = 0;
  int         results_checked = 0;
  int         cmds_sent       = 0;
  int         directed_cmds   = 0;
  int         config_writes   = 0;
  int         full_seen       = 0;
  int         dup_seen        = 0;
  int         unknown_seen    = 0;
  int         override_seen   = 0;

  function automatic int find_slot(logic [7:0] id);
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (ent_valid[i] && ent_src[i] == id) return i;
    end
    return -1;
  endfunction

  function automatic int free_slot();
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (!ent_valid[i]) return i;
    end
    return -1;
  endfunction

  // highest level wins, lower order key on ties
  function automatic bit pick_highest();
    int best;
    best = -1;
    for (int i = 0; i < MAX_SOURCES; i++) begin
      if (ent_valid[i] && (best < 0 || ent_lvl[i] > ent_lvl[best] ||
          (ent_lvl[i] == ent_lvl[best] && ent_key[i] < ent_key[best]))) best = i;
    end
    if (best >= 0 && !ovr_valid) begin
      act_valid = 1'b1;
      act_src   = ent_src[best];
      cur_lvl   = ent_lvl[best];
    end
    return best >= 0;
  endfunction

  function automatic result_t merge_step(item_t it);
    result_t    res;
    logic [1:0] st;
    logic       hit_ovr;
    int         slot;
    int         scaled;
    st      = STATUS_OK;
    hit_ovr = ovr_valid && ovr_src == it.source_id;
    case (it.kind)
      KIND_REGISTER: begin
        if (find_slot(it.source_id) >= 0) begin
          st = STATUS_DUPLICATE;
        end else if (it.source_type == TYPE_EDITOR) begin
          ovr_valid = 1'b1;
          ovr_src   = it.source_id;
          act_valid = 1'b1;
          act_src   = it.source_id;
          cur_lvl   = it.level;
        end else if (cfg_ltp) begin
          if (!ovr_valid) cur_lvl = it.level;
        end else begin
          slot = free_slot();
          if (slot < 0) begin
            st = STATUS_FULL;
          end else begin
            ent_valid[slot] = 1'b1;
            ent_src[slot]   = it.source_id;
            ent_lvl[slot]   = it.level;
            if (it.source_type == TYPE_CROSSFADER) begin
              ent_key[slot] = front_key;
              front_key     = front_key - 1'b1;
            end else begin
              ent_key[slot] = back_key;
              back_key      = back_key + 1'b1;
            end
            void'(pick_highest());
          end
        end
      end
      KIND_SET_LEVEL: begin
        if (hit_ovr || (cfg_ltp && !ovr_valid)) begin
          cur_lvl = it.level;
        end else begin
          slot = find_slot(it.source_id);
          if (slot >= 0) ent_lvl[slot] = it.level;
          else st = STATUS_UNKNOWN;
          void'(pick_highest());
        end
      end
      KIND_UNREGISTER: begin
        if (hit_ovr) begin
          ovr_valid = 1'b0;
          act_valid = 1'b0;
          act_src   = 8'd0;
        end
        if (!cfg_ltp) begin
          slot = find_slot(it.source_id);
          if (slot >= 0) ent_valid[slot] = 1'b0;
          else if (!hit_ovr) st = STATUS_UNKNOWN;
          if (!pick_highest() && !ovr_valid) begin
            act_valid = 1'b0;
            act_src   = 8'd0;
            cur_lvl   = cfg_default;
          end
        end
      end
      default: ;
    endcase
    if (cfg_bypass) begin
      scaled = int'(cur_lvl);
    end else begin
      scaled = int'(cur_lvl) * int'(it.master_level) / LEVEL_MAX;
      if (scaled > 255) scaled = 255;
    end
    res.merged_level    = cur_lvl;
    res.output_level    = scaled[7:0];
    res.active_valid    = act_valid;
    res.active_source   = act_valid ? act_src : 8'd0;
    res.override_active = ovr_valid;
    res.status          = st;
    return res;
  endfunction

  task automatic flag(string field, logic [7:0] want, logic [7:0] got);
    mismatch_count++;
    $display("[%0t] %s mismatch: expected %h, got %h", $time, field, want, got);
  endtask

  always @(posedge clk_i) begin
    result_t want;
    if (rst_ni && done_o) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        $display("[%0t] unexpected result: expected none, got %h", $time, result_o);
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        if (result_o.merged_level !== want.merged_level)
          flag("merged_level", want.merged_level, result_o.merged_level);
        if (result_o.output_level !== want.output_level)
          flag("output_level", want.output_level, result_o.output_level);
        if (result_o.active_valid !== want.active_valid)
          flag("active_valid", want.active_valid, result_o.active_valid);
        if (result_o.active_source !== want.active_source)
          flag("active_source", want.active_source, result_o.active_source);
        if (result_o.override_active !== want.override_active)
          flag("override_active", want.override_active, result_o.override_active);
        if (result_o.status !== want.status)
          flag("status", want.status, result_o.status);
      end
    end
  end

  // hold the command until the transfer, then record its expected result
  task automatic send_cmd(item_t it);
    result_t want;
    start  <= 1'b1;
    item_i <= it;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    want = merge_step(it);
    pending_results = {pending_results, want};
    cmds_sent++;
    case (want.status)
      STATUS_FULL:      full_seen++;
      STATUS_DUPLICATE: dup_seen++;
      STATUS_UNKNOWN:   unknown_seen++;
      default: ;
    endcase
    if (want.override_active) override_seen++;
  endtask

  task automatic pause(int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {24'd0, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    config_writes++;
    case (idx)
      REG_MERGE_MODE:    cfg_ltp     = val[0];
      REG_DEFAULT_LEVEL: cfg_default = val;
      REG_BYPASS_MASTER: cfg_bypass  = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  task automatic read_reg(logic [1:0] idx, logic [7:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (prdata !== {24'd0, want}) begin
      mismatch_count++;
      $display("[%0t] register %0d readback mismatch: expected %h, got %h",
               $time, idx, {24'd0, want}, prdata);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(logic ltp, logic [7:0] dflt, logic bypass);
    drain();
    write_reg(REG_MERGE_MODE, {7'd0, ltp});
    write_reg(REG_DEFAULT_LEVEL, dflt);
    write_reg(REG_BYPASS_MASTER, {7'd0, bypass});
    read_reg(REG_MERGE_MODE, {7'd0, ltp});
    read_reg(REG_DEFAULT_LEVEL, dflt);
    read_reg(REG_BYPASS_MASTER, {7'd0, bypass});
  endtask

  function automatic item_t cmd(logic [1:0] kind, logic [7:0] id, logic [1:0] stype,
                                logic [7:0] lvl, logic [7:0] master);
    item_t it;
    it.kind         = kind;
    it.source_id    = id;
    it.source_type  = stype;
    it.level        = lvl;
    it.master_level = master;
    return it;
  endfunction

  function automatic logic [7:0] rand_level();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2, 3:    return 8'h80;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic item_t rand_cmd();
    item_t it;
    int    r;
    r = $urandom_range(99);
    it.kind = r < 35 ? KIND_REGISTER : r < 75 ? KIND_SET_LEVEL :
              r < 95 ? KIND_UNREGISTER : KIND_NONE;
    it.source_id = ($urandom_range(9) == 0) ? 8'($urandom_range(255))
                                            : id_pool[$urandom_range(POOL_SIZE - 1)];
    if (ovr_valid && it.kind != KIND_REGISTER && $urandom_range(3) == 0)
      it.source_id = ovr_src;
    r = $urandom_range(99);
    it.source_type = r < 8 ? TYPE_EDITOR : r < 33 ? TYPE_CROSSFADER :
                     r < 38 ? TYPE_RESERVED : TYPE_NORMAL;
    it.level        = rand_level();
    it.master_level = rand_level();
    return it;
  endfunction

  task automatic test_htp_directed();
    set_config(1'b0, 8'h00, 1'b0);
    send_cmd(cmd(KIND_NONE,       8'h00, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'h00, TYPE_NORMAL,     8'h00, 8'h00));
    send_cmd(cmd(KIND_REGISTER,   8'hFF, TYPE_CROSSFADER, 8'hFF, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'hFF, TYPE_NORMAL,     8'h10, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'h5A, TYPE_RESERVED,   8'hFF, 8'h80));
    send_cmd(cmd(KIND_REGISTER,   8'h3C, TYPE_CROSSFADER, 8'hFF, 8'h7F));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h3C, TYPE_NORMAL,     8'h64, 8'hFF));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h33, TYPE_NORMAL,     8'hC8, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'hFF, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'h33, TYPE_NORMAL,     8'h00, 8'h01));
    pause(3);
    send_cmd(cmd(KIND_UNREGISTER, 8'h5A, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'h3C, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'h00, TYPE_NORMAL,     8'h00, 8'hFF));
  endtask

  task automatic test_override_directed();
    set_config(1'b0, 8'hFF, 1'b0);
    send_cmd(cmd(KIND_REGISTER,   8'hA5, TYPE_EDITOR,     8'h4D, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'h01, TYPE_NORMAL,     8'hF0, 8'hFF));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h01, TYPE_NORMAL,     8'hFE, 8'hFF));
    send_cmd(cmd(KIND_SET_LEVEL,  8'hA5, TYPE_NORMAL,     8'h0A, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'hA6, TYPE_EDITOR,     8'h22, 8'h80));
    send_cmd(cmd(KIND_UNREGISTER, 8'hA5, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'hA6, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'h01, TYPE_NORMAL,     8'h00, 8'hFF));
  endtask

  task automatic test_ltp_directed();
    set_config(1'b1, 8'hFF, 1'b1);
    send_cmd(cmd(KIND_REGISTER,   8'h10, TYPE_NORMAL,     8'hC8, 8'h00));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h10, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h77, TYPE_NORMAL,     8'hFF, 8'h40));
    send_cmd(cmd(KIND_UNREGISTER, 8'h10, TYPE_NORMAL,     8'h00, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'h20, TYPE_EDITOR,     8'h32, 8'hFF));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h77, TYPE_NORMAL,     8'h63, 8'hFF));
    send_cmd(cmd(KIND_REGISTER,   8'h30, TYPE_CROSSFADER, 8'h01, 8'hFF));
    send_cmd(cmd(KIND_SET_LEVEL,  8'h20, TYPE_NORMAL,     8'hB4, 8'hFF));
    send_cmd(cmd(KIND_UNREGISTER, 8'h20, TYPE_NORMAL,     8'h00, 8'hFF));
  endtask

  task automatic test_random_mix();
    int idle_pct[4] = '{0, 82, 0, 30};
    int pct;
    for (int p = 0; p < 8; p++) begin
      if (p < 4) set_config(p[0], (p == 1 || p == 2) ? 8'hFF : 8'h00, p[1]);
      else set_config(p[0], 8'($urandom_range(255)), p[1]);
      for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = 8'($urandom_range(255));
      pct = idle_pct[p % 4];
      for (int n = 0; n < 205; n++) begin
        send_cmd(rand_cmd());
        if ($urandom_range(99) < 2) drain();
        else if ($urandom_range(99) < pct) pause($urandom_range(1, 40));
      end
    end
  endtask

  initial begin
    #5_000_000;
    $display("Timeout with %0d results outstanding", pending_results.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_htp_directed();
    test_override_directed();
    test_ltp_directed();
    directed_cmds = cmds_sent;
    test_random_mix();
    drain();
    $display("Sent %0d commands (%0d directed), %0d register writes, %0d results checked",
             cmds_sent, directed_cmds, config_writes, results_checked);
    $display("Statuses seen: %0d table full, %0d duplicate, %0d unknown; %0d under override",
             full_seen, dup_seen, unknown_seen, override_seen);
    if (mismatch_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/hlm_pkg.sv
src/hlm_ram.sv
src/hlm_cfg.sv
src/hlm_scale.sv
src/hlm_core.sv
src/htp_ltp_channel_merge.sv
src/hlm_checker.sv
tb/htp_ltp_channel_merge_tb.sv
